// ----- rtl/tac_pkg.sv -----
// turnstile access controller package: word types, register indexes, timing constants
// shared by the controller, the checker and the testbench; no dependencies

package tac_pkg;

    localparam int TIMER_BITS = 14;
    localparam int BEEP_BITS  = 7;
    localparam int LOCK_BITS  = 8;
    localparam int COUNT_BITS = 3;
    localparam int CFG_BITS   = 14;
    localparam int INDEX_BITS = 3;

    localparam logic [BEEP_BITS-1:0]  BEEP_SHORT = BEEP_BITS'(50);
    localparam logic [BEEP_BITS-1:0]  BEEP_LONG  = BEEP_BITS'(100);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;

    // register indexes
    localparam logic [INDEX_BITS-1:0] REG_PASS_DIRECTION   = 3'd0;
    localparam logic [INDEX_BITS-1:0] REG_CONTINUOUS_MODE  = 3'd1;
    localparam logic [INDEX_BITS-1:0] REG_EXIT_LOCK        = 3'd2;
    localparam logic [INDEX_BITS-1:0] REG_MULTIPULSE       = 3'd3;
    localparam logic [INDEX_BITS-1:0] REG_MAX_PASSES       = 3'd4;
    localparam logic [INDEX_BITS-1:0] REG_COLLECT_WINDOW   = 3'd5;
    localparam logic [INDEX_BITS-1:0] REG_PASS_WINDOW      = 3'd6;
    localparam logic [INDEX_BITS-1:0] REG_LOCK_PULSE       = 3'd7;

    // reset values
    localparam logic [COUNT_BITS-1:0] MAX_PASSES_RST     = 3'd5;
    localparam logic [CFG_BITS-1:0]   COLLECT_WINDOW_RST = 14'd4883;
    localparam logic [CFG_BITS-1:0]   PASS_WINDOW_RST    = 14'd9767;
    localparam logic [LOCK_BITS-1:0]  LOCK_PULSE_RST     = 8'd195;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_COLLECT = 3'b010,
        PH_PASS    = 3'b100
    } phase_t;

    typedef struct packed {
        logic pass_request;
        logic rest_released;
        logic cw_switch;
        logic ccw_switch;
    } tick_t;

    typedef struct packed {
        logic                  solenoid_on;
        logic [COUNT_BITS-1:0] led_count;
        logic                  beep_on;
        logic                  window_active;
    } status_t;

endpackage

// ----- rtl/turnstile_access_controller.sv -----
// turnstile access controller top level: tick input register, state update, status register
// depends on tac_pkg

// One status word comes out for every tick word taken in: the tick is captured in an input
// register, the whole state update for it is combinational, and the resulting status lands
// in an output register. A new tick is taken every cycle while the status side keeps up; a
// held status stalls the tick side only once the input register is also full.
// Configuration writes take effect on the next tick and are meant for idle times.
module turnstile_access_controller
    import tac_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tick_valid,
    output logic                  tick_stall,
    input  tick_t                 tick,
    output logic                  status_valid,
    input  logic                  status_stall,
    output status_t               status,
    input  logic                  cfg_we,
    input  logic [INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]   cfg_data
);

    // configuration registers
    logic                  pass_direction_reg;
    logic                  continuous_mode_reg;
    logic                  exit_lock_reg;
    logic                  multipulse_reg;
    logic [COUNT_BITS-1:0] max_passes_reg;
    logic [CFG_BITS-1:0]   collect_window_reg;
    logic [CFG_BITS-1:0]   pass_window_reg;
    logic [LOCK_BITS-1:0]  lock_pulse_reg;

    // pipeline
    logic    in_valid_reg;
    tick_t   in_word_reg;
    logic    out_valid_reg;
    status_t out_word_reg;
    status_t out_word_next;
    logic    advance;

    // controller state
    phase_t                phase_reg, phase_next;
    logic [TIMER_BITS-1:0] window_timer_reg, window_timer_next;
    logic [LOCK_BITS-1:0]  solenoid_timer_reg, solenoid_timer_next;
    logic [BEEP_BITS-1:0]  beep_timer_reg, beep_timer_next;
    logic [COUNT_BITS-1:0] granted_reg, granted_next;
    logic [COUNT_BITS-1:0] remaining_reg, remaining_next;
    logic                  seen_forward_reg, seen_forward_next;
    logic                  seen_reverse_reg, seen_reverse_next;
    logic                  press_armed_reg, press_armed_next;

    logic                  fwd, rev, press, rel, req;
    logic [COUNT_BITS-1:0] limit;
    logic [TIMER_BITS-1:0] collect_len, pass_len;

    assign advance      = in_valid_reg && (!out_valid_reg || !status_stall);
    assign tick_stall   = in_valid_reg && !advance;
    assign status_valid = out_valid_reg;
    assign status       = out_word_reg;

    assign req   = in_word_reg.pass_request;
    assign rel   = in_word_reg.rest_released;
    assign fwd   = pass_direction_reg ? in_word_reg.ccw_switch : in_word_reg.cw_switch;
    assign rev   = pass_direction_reg ? in_word_reg.cw_switch : in_word_reg.ccw_switch;
    assign press = req && press_armed_reg;
    assign limit = (max_passes_reg == '0) ? COUNT_BITS'(1) : max_passes_reg;

    assign collect_len = TIMER_BITS'(collect_window_reg);
    assign pass_len    = TIMER_BITS'(pass_window_reg);

    always_comb
    begin
        phase_next          = phase_reg;
        window_timer_next   = window_timer_reg;
        solenoid_timer_next = solenoid_timer_reg;
        beep_timer_next     = beep_timer_reg;
        granted_next        = granted_reg;
        remaining_next      = remaining_reg;
        seen_forward_next   = seen_forward_reg;
        seen_reverse_next   = seen_reverse_reg;
        press_armed_next    = !req;

        if (solenoid_timer_reg != '0)
            solenoid_timer_next = solenoid_timer_reg - LOCK_BITS'(1);
        if (beep_timer_reg != '0)
            beep_timer_next = beep_timer_reg - BEEP_BITS'(1);

        case (phase_reg)
            PH_COLLECT:
            begin
                if (rel && fwd)
                begin
                    // rotation closes collection early
                    seen_forward_next = 1'b1;
                    phase_next        = PH_PASS;
                    remaining_next    = granted_reg;
                    window_timer_next = pass_len;
                    seen_reverse_next = 1'b0;
                end
                else if (press)
                begin
                    if (granted_reg != COUNT_MAX)
                        granted_next = granted_reg + COUNT_BITS'(1);
                    beep_timer_next   = BEEP_SHORT;
                    window_timer_next = collect_len;
                    if (granted_next >= limit)
                    begin
                        phase_next        = PH_PASS;
                        remaining_next    = granted_next;
                        window_timer_next = pass_len;
                        seen_reverse_next = 1'b0;
                    end
                end
                else if (window_timer_reg <= TIMER_BITS'(1))
                begin
                    phase_next        = PH_PASS;
                    remaining_next    = granted_reg;
                    window_timer_next = pass_len;
                    seen_reverse_next = 1'b0;
                end
                else
                begin
                    window_timer_next = window_timer_reg - TIMER_BITS'(1);
                end
            end

            PH_PASS:
            begin
                if (rel && rev && !seen_forward_reg)
                    solenoid_timer_next = lock_pulse_reg;
                if (fwd)
                    seen_forward_next = 1'b1;
                if (rev)
                    seen_reverse_next = 1'b1;
                if (seen_forward_next && seen_reverse_next && !rel)
                begin
                    beep_timer_next   = BEEP_LONG;
                    seen_forward_next = 1'b0;
                    seen_reverse_next = 1'b0;
                    remaining_next    = remaining_reg - COUNT_BITS'(1);
                    if (remaining_next == '0)
                    begin
                        phase_next        = PH_IDLE;
                        window_timer_next = '0;
                        granted_next      = '0;
                    end
                    else
                    begin
                        window_timer_next = pass_len;
                    end
                end
                else if (window_timer_reg <= TIMER_BITS'(1))
                begin
                    // window ran out: drop what is left
                    phase_next        = PH_IDLE;
                    window_timer_next = '0;
                    granted_next      = '0;
                    remaining_next    = '0;
                    seen_forward_next = 1'b0;
                    seen_reverse_next = 1'b0;
                end
                else
                begin
                    window_timer_next = window_timer_reg - TIMER_BITS'(1);
                end
            end

            default:
            begin
                phase_next = PH_IDLE;
                if (continuous_mode_reg && req)
                begin
                    if (exit_lock_reg && rel && rev && !seen_forward_reg)
                        solenoid_timer_next = lock_pulse_reg;
                    if (fwd)
                        seen_forward_next = 1'b1;
                    if (rev)
                        seen_reverse_next = 1'b1;
                    if (seen_forward_next && seen_reverse_next && !rel)
                    begin
                        beep_timer_next   = BEEP_SHORT;
                        seen_forward_next = 1'b0;
                        seen_reverse_next = 1'b0;
                    end
                end
                else
                begin
                    if (rel && (exit_lock_reg || fwd))
                        solenoid_timer_next = lock_pulse_reg;
                    if (!continuous_mode_reg && press)
                    begin
                        beep_timer_next   = BEEP_SHORT;
                        seen_forward_next = 1'b0;
                        seen_reverse_next = 1'b0;
                        if (multipulse_reg)
                        begin
                            granted_next = COUNT_BITS'(1);
                            if (limit == COUNT_BITS'(1))
                            begin
                                phase_next        = PH_PASS;
                                remaining_next    = COUNT_BITS'(1);
                                window_timer_next = pass_len;
                            end
                            else
                            begin
                                phase_next        = PH_COLLECT;
                                window_timer_next = collect_len;
                            end
                        end
                        else
                        begin
                            granted_next      = '0;
                            phase_next        = PH_PASS;
                            remaining_next    = COUNT_BITS'(1);
                            window_timer_next = pass_len;
                        end
                    end
                end
            end
        endcase

        out_word_next.solenoid_on   = (solenoid_timer_next != '0);
        out_word_next.beep_on       = (beep_timer_next != '0);
        out_word_next.window_active = (phase_next == PH_COLLECT) || (phase_next == PH_PASS);
        if (phase_next == PH_COLLECT)
            out_word_next.led_count = granted_next;
        else if (phase_next == PH_PASS)
            out_word_next.led_count = remaining_next;
        else
            out_word_next.led_count = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_direction_reg  <= 1'b0;
            continuous_mode_reg <= 1'b0;
            exit_lock_reg       <= 1'b0;
            multipulse_reg      <= 1'b0;
            max_passes_reg      <= MAX_PASSES_RST;
            collect_window_reg  <= COLLECT_WINDOW_RST;
            pass_window_reg     <= PASS_WINDOW_RST;
            lock_pulse_reg      <= LOCK_PULSE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PASS_DIRECTION:  pass_direction_reg  <= cfg_data[0];
                REG_CONTINUOUS_MODE: continuous_mode_reg <= cfg_data[0];
                REG_EXIT_LOCK:       exit_lock_reg       <= cfg_data[0];
                REG_MULTIPULSE:      multipulse_reg      <= cfg_data[0];
                REG_MAX_PASSES:      max_passes_reg      <= cfg_data[COUNT_BITS-1:0];
                REG_COLLECT_WINDOW:  collect_window_reg  <= cfg_data;
                REG_PASS_WINDOW:     pass_window_reg     <= cfg_data;
                REG_LOCK_PULSE:      lock_pulse_reg      <= cfg_data[LOCK_BITS-1:0];
                default:             lock_pulse_reg      <= lock_pulse_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            phase_reg          <= PH_IDLE;
            window_timer_reg   <= '0;
            solenoid_timer_reg <= '0;
            beep_timer_reg     <= '0;
            granted_reg        <= '0;
            remaining_reg      <= '0;
            seen_forward_reg   <= 1'b0;
            seen_reverse_reg   <= 1'b0;
            press_armed_reg    <= 1'b0;
        end
        else
        begin
            if (tick_valid && !tick_stall)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!status_stall)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                phase_reg          <= phase_next;
                window_timer_reg   <= window_timer_next;
                solenoid_timer_reg <= solenoid_timer_next;
                beep_timer_reg     <= beep_timer_next;
                granted_reg        <= granted_next;
                remaining_reg      <= remaining_next;
                seen_forward_reg   <= seen_forward_next;
                seen_reverse_reg   <= seen_reverse_next;
                press_armed_reg    <= press_armed_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (tick_valid && !tick_stall)
            in_word_reg <= tick;
        if (advance)
            out_word_reg <= out_word_next;
    end

`ifndef SYNTHESIS
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> window_timer_reg == '0 && granted_reg == '0
                                 && remaining_reg == '0)
        else $error("idle phase holds leftover window state");

    a_pass_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PASS |-> remaining_reg != '0)
        else $error("passage window open with no passes left");

    a_beep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        beep_timer_reg <= BEEP_LONG)
        else $error("beep timer beyond longest pulse");

    a_led_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        status_valid && status.led_count != '0 |-> status.window_active)
        else $error("led count shown outside a window");

    a_word_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(status_valid) |-> $past(in_valid_reg))
        else $error("status word without a captured tick");
`endif

endmodule

// ----- test/tac_checker.sv -----
// checker for the turnstile access controller: predicts each status word from the tick words
// and register writes it sees, and compares the status words that come out; uses tac_pkg

module tac_checker
    import tac_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tick_valid,
    input  logic                  tick_stall,
    input  tick_t                 tick,
    input  logic                  status_valid,
    input  logic                  status_stall,
    input  status_t               status,
    input  logic                  cfg_we,
    input  logic [INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]   cfg_data,
    output int                    mismatches,
    output int                    awaiting
);
    timeunit 1ns;
    timeprecision 1ps;

    // register copy
    logic                  dir_ccw;
    logic                  cont_mode;
    logic                  exit_lock;
    logic                  multi;
    logic [COUNT_BITS-1:0] max_passes;
    logic [TIMER_BITS-1:0] collect_len;
    logic [TIMER_BITS-1:0] pass_len;
    logic [LOCK_BITS-1:0]  lock_len;

    // controller state
    phase_t                phase;
    logic [TIMER_BITS-1:0] window_left;
    logic [LOCK_BITS-1:0]  lock_left;
    logic [BEEP_BITS-1:0]  beep_left;
    logic [COUNT_BITS-1:0] granted;
    logic [COUNT_BITS-1:0] remaining;
    logic                  seen_fwd;
    logic                  seen_rev;
    logic                  armed;

    status_t predicted_status_q[$];
    status_t want;

    function automatic void return_to_idle();
        phase       = PH_IDLE;
        window_left = '0;
        granted     = '0;
        remaining   = '0;
        seen_fwd    = 1'b0;
        seen_rev    = 1'b0;
    endfunction

    function automatic void open_pass_window(logic [COUNT_BITS-1:0] n);
        phase       = PH_PASS;
        remaining   = n;
        window_left = pass_len;
        seen_rev    = 1'b0;
    endfunction

    // max_passes of zero counts as one
    function automatic bit press_limit_hit();
        logic [COUNT_BITS-1:0] lim;
        lim = (max_passes == '0) ? COUNT_BITS'(1) : max_passes;
        return granted >= lim;
    endfunction

    // a zero length window runs out on its first tick
    function automatic bit window_expired();
        if (window_left <= TIMER_BITS'(1))
        begin
            window_left = '0;
            return 1'b1;
        end
        window_left = window_left - 1'b1;
        return 1'b0;
    endfunction

    function automatic status_t next_status(tick_t t);
        logic    fwd;
        logic    rev;
        logic    press;
        status_t s;
        fwd   = dir_ccw ? t.ccw_switch : t.cw_switch;
        rev   = dir_ccw ? t.cw_switch : t.ccw_switch;
        press = t.pass_request && armed;
        if (lock_left != '0)
            lock_left = lock_left - 1'b1;
        if (beep_left != '0)
            beep_left = beep_left - 1'b1;
        armed = !t.pass_request;

        case (phase)
            PH_COLLECT:
            begin
                if (t.rest_released && fwd)
                begin
                    // rotation closes collection early
                    seen_fwd = 1'b1;
                    open_pass_window(granted);
                end
                else if (press)
                begin
                    if (granted != COUNT_MAX)
                        granted = granted + 1'b1;
                    beep_left   = BEEP_SHORT;
                    window_left = collect_len;
                    if (press_limit_hit())
                        open_pass_window(granted);
                end
                else if (window_expired())
                    open_pass_window(granted);
            end
            PH_PASS:
            begin
                if (t.rest_released && rev && !seen_fwd)
                    lock_left = lock_len;
                if (fwd)
                    seen_fwd = 1'b1;
                if (rev)
                    seen_rev = 1'b1;
                if (seen_fwd && seen_rev && !t.rest_released)
                begin
                    beep_left = BEEP_LONG;
                    seen_fwd  = 1'b0;
                    seen_rev  = 1'b0;
                    remaining = remaining - 1'b1;
                    if (remaining == '0)
                        return_to_idle();
                    else
                        window_left = pass_len;
                end
                else if (window_expired())
                    return_to_idle();
            end
            default:
            begin
                phase = PH_IDLE;
                if (cont_mode && t.pass_request)
                begin
                    if (exit_lock && t.rest_released && rev && !seen_fwd)
                        lock_left = lock_len;
                    if (fwd)
                        seen_fwd = 1'b1;
                    if (rev)
                        seen_rev = 1'b1;
                    if (seen_fwd && seen_rev && !t.rest_released)
                    begin
                        beep_left = BEEP_SHORT;
                        seen_fwd  = 1'b0;
                        seen_rev  = 1'b0;
                    end
                end
                else
                begin
                    if (t.rest_released && (exit_lock || fwd))
                        lock_left = lock_len;
                    if (!cont_mode && press)
                    begin
                        beep_left = BEEP_SHORT;
                        seen_fwd  = 1'b0;
                        seen_rev  = 1'b0;
                        if (multi)
                        begin
                            granted = COUNT_BITS'(1);
                            if (press_limit_hit())
                                open_pass_window(granted);
                            else
                            begin
                                phase       = PH_COLLECT;
                                window_left = collect_len;
                            end
                        end
                        else
                        begin
                            granted = '0;
                            open_pass_window(COUNT_BITS'(1));
                        end
                    end
                end
            end
        endcase

        s.solenoid_on   = (lock_left != '0);
        s.led_count     = (phase == PH_COLLECT) ? granted :
                          (phase == PH_PASS) ? remaining : '0;
        s.beep_on       = (beep_left != '0);
        s.window_active = (phase != PH_IDLE);
        return s;
    endfunction

    task automatic check_field(string name, logic [COUNT_BITS-1:0] want_v,
                               logic [COUNT_BITS-1:0] got_v);
        if (got_v !== want_v)
        begin
            mismatches++;
            $display("%0t: status %s expected %0d got %0d", $time, name, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_ccw     = 1'b0;
            cont_mode   = 1'b0;
            exit_lock   = 1'b0;
            multi       = 1'b0;
            max_passes  = MAX_PASSES_RST;
            collect_len = COLLECT_WINDOW_RST;
            pass_len    = PASS_WINDOW_RST;
            lock_len    = LOCK_PULSE_RST;
            lock_left   = '0;
            beep_left   = '0;
            armed       = 1'b0;
            return_to_idle();
            predicted_status_q.delete();
            mismatches  = 0;
            awaiting    = 0;
        end
        else
        begin
            if (status_valid && !status_stall)
            begin
                if (predicted_status_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: status word expected none got %b", $time, status);
                end
                else
                begin
                    want = predicted_status_q.pop_front();
                    check_field("solenoid_on", want.solenoid_on, status.solenoid_on);
                    check_field("led_count", want.led_count, status.led_count);
                    check_field("beep_on", want.beep_on, status.beep_on);
                    check_field("window_active", want.window_active, status.window_active);
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PASS_DIRECTION:  dir_ccw     = cfg_data[0];
                    REG_CONTINUOUS_MODE: cont_mode   = cfg_data[0];
                    REG_EXIT_LOCK:       exit_lock   = cfg_data[0];
                    REG_MULTIPULSE:      multi       = cfg_data[0];
                    REG_MAX_PASSES:      max_passes  = cfg_data[COUNT_BITS-1:0];
                    REG_COLLECT_WINDOW:  collect_len = cfg_data[TIMER_BITS-1:0];
                    REG_PASS_WINDOW:     pass_len    = cfg_data[TIMER_BITS-1:0];
                    REG_LOCK_PULSE:      lock_len    = cfg_data[LOCK_BITS-1:0];
                    default: ;
                endcase
            end

            if (tick_valid && !tick_stall)
                predicted_status_q.push_back(next_status(tick));
            awaiting = predicted_status_q.size();
        end
    end

endmodule

// ----- test/tb_turnstile_access_controller.sv -----
// testbench top for the turnstile access controller: clock, reset, tick stimulus, register
// writes and the verdict; depends on tac_pkg, the controller and tac_checker

module tb_turnstile_access_controller;
    import tac_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  tick_valid   = 1'b0;
    tick_t                 tick         = '0;
    logic                  status_stall = 1'b0;
    logic                  cfg_we       = 1'b0;
    logic [INDEX_BITS-1:0] cfg_index    = '0;
    logic [CFG_BITS-1:0]   cfg_data     = '0;
    logic                  tick_stall;
    logic                  status_valid;
    status_t               status;
    int                    mismatches;
    int                    awaiting;

    int   gap_pct   = 0;
    int   stall_pct = 0;
    logic dir_ccw   = 1'b0;
    logic cont_on   = 1'b0;

    turnstile_access_controller dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .tick         (tick),
        .status_valid (status_valid),
        .status_stall (status_stall),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    tac_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .tick         (tick),
        .status_valid (status_valid),
        .status_stall (status_stall),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .awaiting     (awaiting)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
        status_stall <= ($urandom_range(99) < stall_pct);

    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // entered and left at a falling edge
    task automatic send_tick(tick_t t);
        while ($urandom_range(99) < gap_pct)
        begin
            tick_valid <= 1'b0;
            tick       <= tick_t'($urandom_range(15));
            @(negedge clk);
        end
        tick       <= t;
        tick_valid <= 1'b1;
        @(posedge clk);
        while (tick_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // switches given as forward and reverse for the current direction
    task automatic send_motion(logic req, logic rel, logic fwd, logic rev);
        tick_t t;
        t.pass_request  = req;
        t.rest_released = rel;
        t.cw_switch     = dir_ccw ? rev : fwd;
        t.ccw_switch    = dir_ccw ? fwd : rev;
        send_tick(t);
    endtask

    task automatic wait_drained();
        tick_valid <= 1'b0;
        while (awaiting != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // leaves cfg_we high so back to back writes keep it steady
    task automatic write_reg(logic [INDEX_BITS-1:0] idx, int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_BITS'(value);
        @(negedge clk);
    endtask

    task automatic configure(logic dir, logic cont, logic lock, logic multi, int max_p,
                             int collect_t, int pass_t, int pulse_t);
        write_reg(REG_PASS_DIRECTION, dir);
        write_reg(REG_CONTINUOUS_MODE, cont);
        write_reg(REG_EXIT_LOCK, lock);
        write_reg(REG_MULTIPULSE, multi);
        write_reg(REG_MAX_PASSES, max_p);
        write_reg(REG_COLLECT_WINDOW, collect_t);
        write_reg(REG_PASS_WINDOW, pass_t);
        write_reg(REG_LOCK_PULSE, pulse_t);
        cfg_we  <= 1'b0;
        dir_ccw = dir;
        cont_on = cont;
        @(negedge clk);
    endtask

    task automatic run_random(int count);
        int   sent;
        int   kind;
        logic req;
        sent = 0;
        while (sent < count)
        begin
            kind = $urandom_range(9);
            req  = cont_on ? ($urandom_range(7) != 0) : ($urandom_range(7) == 0);
            if (kind <= 2)
            begin
                repeat ($urandom_range(1, 8))
                begin
                    repeat ($urandom_range(1, 3))
                    begin
                        send_motion(1'b0, 1'b0, 1'b0, 1'b0);
                        sent++;
                    end
                    repeat ($urandom_range(1, 2))
                    begin
                        send_motion(1'b1, 1'b0, 1'b0, 1'b0);
                        sent++;
                    end
                end
            end
            else if (kind <= 6)
            begin
                // a full rotation, the wrong way round for kind 6
                repeat ($urandom_range(1, 3))
                begin
                    send_motion(req, 1'b1, kind != 6, kind == 6);
                    sent++;
                end
                repeat ($urandom_range(0, 2))
                begin
                    send_motion(req, 1'b1, 1'b1, 1'b1);
                    sent++;
                end
                repeat ($urandom_range(1, 3))
                begin
                    send_motion(req, 1'b1, kind == 6, kind != 6);
                    sent++;
                end
                repeat ($urandom_range(1, 2))
                begin
                    send_motion(req, 1'b0, 1'b0, 1'b0);
                    sent++;
                end
            end
            else if (kind == 7)
            begin
                repeat ($urandom_range(1, 15))
                begin
                    send_motion(req, 1'b0, 1'b0, 1'b0);
                    sent++;
                end
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    send_tick(tick_t'($urandom_range(15)));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings, single mode: ticks are req rel cw ccw
        send_tick(4'b0000);
        send_tick(4'b0110);   // leaving rest forward without a grant locks
        send_tick(4'b1000);
        send_tick(4'b1110);
        send_tick(4'b1111);
        send_tick(4'b0101);
        send_tick(4'b0000);   // passage complete
        send_tick(4'b1000);
        send_tick(4'b0101);   // wrong way inside the window
        send_tick(4'b0110);
        send_tick(4'b0000);
        send_tick(4'b1111);

        // zero max_passes and zero windows
        wait_drained();
        configure(1'b0, 1'b0, 1'b1, 1'b1, 0, 0, 0, 255);
        send_tick(4'b0000);
        send_tick(4'b1000);
        send_tick(4'b0000);   // window runs out at once
        send_tick(4'b0100);   // exit lock

        // collection closed early by rotation, counter-clockwise forward
        wait_drained();
        configure(1'b1, 1'b0, 1'b0, 1'b1, 7, 3, 2, 1);
        send_tick(4'b0000);
        send_tick(4'b1000);
        send_tick(4'b0000);
        send_tick(4'b1000);
        send_tick(4'b0101);
        send_tick(4'b0111);
        send_tick(4'b0000);
        send_tick(4'b0000);
        send_tick(4'b0000);

        // continuous mode with exit lock
        wait_drained();
        configure(1'b1, 1'b1, 1'b1, 1'b0, 1, 16383, 16383, 5);
        send_tick(4'b1110);
        send_tick(4'b1101);
        send_tick(4'b1000);

        for (int p = 0; p < 6; p++)
        begin
            wait_drained();
            case (p)
                4: configure(1'($urandom_range(1)), 1'b0, 1'($urandom_range(1)), 1'b1,
                             7, 16383, 16383, 255);
                5: configure(1'($urandom_range(1)), 1'b0, 1'b1, 1'b1, 1, 1, 1, 1);
                default: configure(1'($urandom_range(1)),
                                   (p == 3) || ($urandom_range(3) == 0),
                                   1'($urandom_range(1)), 1'($urandom_range(1)),
                                   $urandom_range(7), $urandom_range(1, 12),
                                   $urandom_range(1, 16), $urandom_range(1, 255));
            endcase
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 80; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 80; end
                default: begin gap_pct = 19; stall_pct = 19; end
            endcase
            run_random(38);
            // hold the sender until every status word is back
            wait_drained();
            run_random(38);
        end

        wait_drained();
        if (mismatches == 0 && awaiting == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/tac_pkg.sv
rtl/turnstile_access_controller.sv
test/tac_checker.sv
test/tb_turnstile_access_controller.sv
